// ----- design/tfn_pkg.sv -----
// Shared constants and types for the triangle face normal core.
package tfn_pkg;

   // Stream payload layout
   localparam int POS_W        = 63;
   localparam int NRM_W        = 48;
   localparam int FACE_W       = 16;
   localparam int REQ_FIELDS_W = 3 * POS_W + 3 * NRM_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = 3 * FACE_W;
   localparam int RSP_TUSER_W  = 2;

   // Q1.14 output scaling; quotient never exceeds 1.0, so 15 bits
   localparam int FRAC_BITS    = 14;
   localparam int QUO_BITS     = FRAC_BITS + 1;
   localparam int UNIT_VALUE   = 1 << FRAC_BITS;

   // Result flags, flipped in the low bit
   typedef struct packed {
      logic degenerate;
      logic flipped;
   } rsp_flags_type;

endpackage

// ----- design/triangle_face_normal_core.sv -----
// Triangle face normal core: cross product, integer sqrt and Q1.14 normalize pipeline.
//
//   channel   dir  handshake          payload
//   req_*     in   tvalid / tready    tdata: corner0..2 pos, corner0..2 nrm
//   rsp_*     out  tvalid / tready    tdata: face nx, ny, nz; tuser: flipped, degenerate
//   csr_*     in   we                 wdata: flip_enable (reset 1)
//
// One triangle per cycle sustained while the pipeline is not frozen. The pipeline
// has six arithmetic stages, one bit-stage per square root bit, one bit-stage
// per quotient bit of the three parallel dividers and the output register.
// Reset clears all valid bits; flip_enable returns to 1.
// The pipeline freezes only when the output register and its skid entry both
// hold results, so req_tready stays high while a single result waits.
module triangle_face_normal_core #(
   parameter int COORD_BITS  = 21,
   parameter int NORMAL_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // corner0_pos, corner1_pos, corner2_pos, corner0_nrm, corner1_nrm, corner2_nrm
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tfn_pkg::REQ_TDATA_W-1:0] req_tdata,
   // face_nx, face_ny, face_nz
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tfn_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // flipped, degenerate
   output logic [tfn_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                            csr_we,
   input  logic                            csr_wdata
);
   import tfn_pkg::*;

   localparam int EDGE_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int C_W    = PROD_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int LO_W   = MAG_W / 2;
   localparam int HI_W   = MAG_W - LO_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int ROOT_W = MAG_W + 1;
   localparam int SUM_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int DP_W   = C_W + NORMAL_BITS;
   localparam int DOT_W  = DP_W + 2;
   localparam int CMP_W  = ROOT_W + QUO_BITS;

   // Configuration register
   logic flip_en_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         flip_en_ff <= 1'b1;
      end else if (csr_we) begin
         flip_en_ff <= csr_wdata;
      end
   end

   // Skid entry full means the whole pipeline holds
   logic skid_vld_ff;
   logic adv;
   assign adv        = !skid_vld_ff;
   assign req_tready = adv;

   // ---------------- stage 1: unpack, edges ----------------
   logic                          s1_vld_ff;
   logic signed [EDGE_W-1:0]      e1_ff [3];
   logic signed [EDGE_W-1:0]      e2_ff [3];
   logic signed [NORMAL_BITS-1:0] n1_ff [3][3];
   logic signed [EDGE_W-1:0]      e1_in [3];
   logic signed [EDGE_W-1:0]      e2_in [3];
   logic signed [NORMAL_BITS-1:0] n_in  [3][3];

   always_comb begin
      logic signed [COORD_BITS-1:0] p0, p1, p2;
      for (int j = 0; j < 3; j++) begin
         p0 = $signed(req_tdata[0*POS_W + j*COORD_BITS +: COORD_BITS]);
         p1 = $signed(req_tdata[1*POS_W + j*COORD_BITS +: COORD_BITS]);
         p2 = $signed(req_tdata[2*POS_W + j*COORD_BITS +: COORD_BITS]);
         e1_in[j] = EDGE_W'(p1) - EDGE_W'(p0);
         e2_in[j] = EDGE_W'(p2) - EDGE_W'(p0);
         for (int i = 0; i < 3; i++) begin
            n_in[i][j] = $signed(req_tdata[3*POS_W + i*NRM_W + j*NORMAL_BITS +: NORMAL_BITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         n1_ff <= n_in;
      end
   end

   // ---------------- stage 2: cross product terms ----------------
   logic                          s2_vld_ff;
   logic signed [PROD_W-1:0]      pa_ff [3];
   logic signed [PROD_W-1:0]      pb_ff [3];
   logic signed [NORMAL_BITS-1:0] n2_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            pa_ff[j] <= PROD_W'(e1_ff[(j+1)%3]) * PROD_W'(e2_ff[(j+2)%3]);
            pb_ff[j] <= PROD_W'(e1_ff[(j+2)%3]) * PROD_W'(e2_ff[(j+1)%3]);
         end
         n2_ff <= n1_ff;
      end
   end

   // ---------------- stage 3: cross product, magnitudes ----------------
   logic                          s3_vld_ff;
   logic signed [C_W-1:0]         c3_ff   [3];
   logic [2:0][MAG_W-1:0]         mag3_ff;
   logic signed [NORMAL_BITS-1:0] n3_ff   [3][3];
   logic signed [C_W-1:0]         c_in    [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         c_in[j] = C_W'(pa_ff[j]) - C_W'(pb_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            c3_ff[j]   <= c_in[j];
            mag3_ff[j] <= c_in[j][C_W-1] ? MAG_W'(-c_in[j]) : MAG_W'(c_in[j]);
         end
         n3_ff <= n2_ff;
      end
   end

   // ---------------- stage 4: square partials, dot products ----------------
   logic                      s4_vld_ff;
   logic [2*HI_W-1:0]         hh_ff [3];
   logic [HI_W+LO_W-1:0]      hl_ff [3];
   logic [2*LO_W-1:0]         ll_ff [3];
   logic signed [DP_W-1:0]    dp_ff [3][3];
   logic [2:0][MAG_W-1:0]     mag4_ff;
   logic [2:0]                neg4_ff;
   logic                      degen4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            hh_ff[j] <= (2*HI_W)'(mag3_ff[j][MAG_W-1:LO_W]) * (2*HI_W)'(mag3_ff[j][MAG_W-1:LO_W]);
            hl_ff[j] <= (HI_W+LO_W)'(mag3_ff[j][MAG_W-1:LO_W])
                        * (HI_W+LO_W)'(mag3_ff[j][LO_W-1:0]);
            ll_ff[j] <= (2*LO_W)'(mag3_ff[j][LO_W-1:0]) * (2*LO_W)'(mag3_ff[j][LO_W-1:0]);
            neg4_ff[j] <= c3_ff[j][C_W-1];
            for (int i = 0; i < 3; i++) begin
               dp_ff[i][j] <= DP_W'(c3_ff[j]) * DP_W'(n3_ff[i][j]);
            end
         end
         mag4_ff   <= mag3_ff;
         degen4_ff <= (mag3_ff == '0);
      end
   end

   // ---------------- stage 5: squares, dot sums ----------------
   logic                      s5_vld_ff;
   logic [SQ_W-1:0]           sq5_ff  [3];
   logic signed [DOT_W-1:0]   dsum_ff [3];
   logic [2:0][MAG_W-1:0]     mag5_ff;
   logic [2:0]                neg5_ff;
   logic                      degen5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            sq5_ff[j] <= (SQ_W'(hh_ff[j]) << (2*LO_W)) + (SQ_W'(hl_ff[j]) << (LO_W+1))
                         + SQ_W'(ll_ff[j]);
         end
         for (int i = 0; i < 3; i++) begin
            dsum_ff[i] <= DOT_W'(dp_ff[i][0]) + DOT_W'(dp_ff[i][1]) + DOT_W'(dp_ff[i][2]);
         end
         mag5_ff   <= mag4_ff;
         neg5_ff   <= neg4_ff;
         degen5_ff <= degen4_ff;
      end
   end

   // ---------------- stage 6: sum of squares, opposition test ----------------
   logic                      s6_vld_ff;
   logic [SUM_W-1:0]          sum6_ff;
   logic [2:0][MAG_W-1:0]     mag6_ff;
   logic [2:0]                neg6_ff;
   logic                      alln6_ff;
   logic                      degen6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum6_ff   <= SUM_W'(sq5_ff[0]) + SUM_W'(sq5_ff[1]) + SUM_W'(sq5_ff[2]);
         alln6_ff  <= dsum_ff[0][DOT_W-1] & dsum_ff[1][DOT_W-1] & dsum_ff[2][DOT_W-1];
         mag6_ff   <= mag5_ff;
         neg6_ff   <= neg5_ff;
         degen6_ff <= degen5_ff;
      end
   end

   // ---------------- square root: one result bit per stage ----------------
   logic                  sq_vld_ff   [ROOT_W];
   logic [REM_W-1:0]      sq_rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]     sq_root_ff  [ROOT_W];
   logic [SUM_W-1:0]      sq_rad_ff   [ROOT_W];
   logic [2:0][MAG_W-1:0] sq_mag_ff   [ROOT_W];
   logic [2:0]            sq_neg_ff   [ROOT_W];
   logic                  sq_alln_ff  [ROOT_W];
   logic                  sq_degen_ff [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      logic                  vld_in;
      logic [REM_W-1:0]      rem_in;
      logic [ROOT_W-1:0]     root_in;
      logic [SUM_W-1:0]      rad_in;
      logic [2:0][MAG_W-1:0] mag_in;
      logic [2:0]            neg_in;
      logic                  alln_in;
      logic                  degen_in;
      logic [REM_W-1:0]      rem_t;
      logic [REM_W-1:0]      trial;

      if (g == 0) begin : g_first
         assign vld_in   = s6_vld_ff;
         assign rem_in   = '0;
         assign root_in  = '0;
         assign rad_in   = sum6_ff;
         assign mag_in   = mag6_ff;
         assign neg_in   = neg6_ff;
         assign alln_in  = alln6_ff;
         assign degen_in = degen6_ff;
      end else begin : g_next
         assign vld_in   = sq_vld_ff[g-1];
         assign rem_in   = sq_rem_ff[g-1];
         assign root_in  = sq_root_ff[g-1];
         assign rad_in   = sq_rad_ff[g-1];
         assign mag_in   = sq_mag_ff[g-1];
         assign neg_in   = sq_neg_ff[g-1];
         assign alln_in  = sq_alln_ff[g-1];
         assign degen_in = sq_degen_ff[g-1];
      end

      // bring down two radicand bits, try root*4+1
      assign rem_t = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
      assign trial = {root_in, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[g] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[g] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem_t >= trial) begin
               sq_rem_ff[g]  <= rem_t - trial;
               sq_root_ff[g] <= {root_in[ROOT_W-2:0], 1'b1};
            end else begin
               sq_rem_ff[g]  <= rem_t;
               sq_root_ff[g] <= {root_in[ROOT_W-2:0], 1'b0};
            end
            sq_rad_ff[g]   <= rad_in << 2;
            sq_mag_ff[g]   <= mag_in;
            sq_neg_ff[g]   <= neg_in;
            sq_alln_ff[g]  <= alln_in;
            sq_degen_ff[g] <= degen_in;
         end
      end
   end

   // ---------------- divide: one quotient bit per stage, three lanes ----------------
   logic                       dv_vld_ff   [QUO_BITS];
   logic [2:0][CMP_W-1:0]      dv_rem_ff   [QUO_BITS];
   logic [2:0][QUO_BITS-1:0]   dv_q_ff     [QUO_BITS];
   logic [ROOT_W-1:0]          dv_root_ff  [QUO_BITS];
   logic [2:0]                 dv_neg_ff   [QUO_BITS];
   logic                       dv_alln_ff  [QUO_BITS];
   logic                       dv_degen_ff [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      localparam int SH = QUO_BITS - 1 - k;
      logic                     vld_in;
      logic [2:0][CMP_W-1:0]    rem_in;
      logic [2:0][QUO_BITS-1:0] q_in;
      logic [ROOT_W-1:0]        root_in;
      logic [2:0]               neg_in;
      logic                     alln_in;
      logic                     degen_in;
      logic [CMP_W-1:0]         dsh;

      if (k == 0) begin : g_first
         assign vld_in   = sq_vld_ff[ROOT_W-1];
         assign root_in  = sq_root_ff[ROOT_W-1];
         assign q_in     = '0;
         assign neg_in   = sq_neg_ff[ROOT_W-1];
         assign alln_in  = sq_alln_ff[ROOT_W-1];
         assign degen_in = sq_degen_ff[ROOT_W-1];
         for (genvar j = 0; j < 3; j++) begin : g_lane
            assign rem_in[j] = CMP_W'(sq_mag_ff[ROOT_W-1][j]) << FRAC_BITS;
         end
      end else begin : g_next
         assign vld_in   = dv_vld_ff[k-1];
         assign root_in  = dv_root_ff[k-1];
         assign q_in     = dv_q_ff[k-1];
         assign rem_in   = dv_rem_ff[k-1];
         assign neg_in   = dv_neg_ff[k-1];
         assign alln_in  = dv_alln_ff[k-1];
         assign degen_in = dv_degen_ff[k-1];
      end

      assign dsh = CMP_W'(root_in) << SH;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int j = 0; j < 3; j++) begin
               if (rem_in[j] >= dsh) begin
                  dv_rem_ff[k][j] <= rem_in[j] - dsh;
                  dv_q_ff[k][j]   <= q_in[j] | (QUO_BITS'(1) << SH);
               end else begin
                  dv_rem_ff[k][j] <= rem_in[j];
                  dv_q_ff[k][j]   <= q_in[j];
               end
            end
            dv_root_ff[k]  <= root_in;
            dv_neg_ff[k]   <= neg_in;
            dv_alln_ff[k]  <= alln_in;
            dv_degen_ff[k] <= degen_in;
         end
      end
   end

   // ---------------- result: sign, flip, degenerate ----------------
   logic                   last_vld;
   logic [RSP_TDATA_W-1:0] last_data;
   rsp_flags_type          last_flags;

   always_comb begin
      logic [FACE_W-1:0] mag;
      logic              flip;
      flip = flip_en_ff & dv_alln_ff[QUO_BITS-1] & !dv_degen_ff[QUO_BITS-1];
      for (int j = 0; j < 3; j++) begin
         mag = FACE_W'(dv_q_ff[QUO_BITS-1][j]);
         if (dv_degen_ff[QUO_BITS-1]) begin
            last_data[j*FACE_W +: FACE_W] = '0;
         end else if (dv_neg_ff[QUO_BITS-1][j] ^ flip) begin
            last_data[j*FACE_W +: FACE_W] = -mag;
         end else begin
            last_data[j*FACE_W +: FACE_W] = mag;
         end
      end
      last_flags.flipped    = flip;
      last_flags.degenerate = dv_degen_ff[QUO_BITS-1];
   end
   assign last_vld = dv_vld_ff[QUO_BITS-1];

   // ---------------- output register with skid entry ----------------
   logic                   rsp_vld_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, skid_data_ff;
   rsp_flags_type          rsp_flags_ff, skid_flags_ff;
   logic                   out_free;

   assign out_free = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff  <= skid_vld_ff | last_vld;
         skid_vld_ff <= 1'b0;
      end else if (!skid_vld_ff && last_vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_vld_ff) begin
            rsp_data_ff  <= skid_data_ff;
            rsp_flags_ff <= skid_flags_ff;
         end else begin
            rsp_data_ff  <= last_data;
            rsp_flags_ff <= last_flags;
         end
      end else if (!skid_vld_ff) begin
         skid_data_ff  <= last_data;
         skid_flags_ff <= last_flags;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule

// ----- design/tfn_checker.sv -----
// Port-level checks for the triangle face normal core, bound to the top level.
module tfn_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tfn_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [tfn_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import tfn_pkg::*;

   // A stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Degenerate triangles give a zero, unflipped normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0 && !rsp_tuser[0])
      else $error("degenerate result not zero");

   // Components stay within plus or minus 1.0 in Q1.14
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[FACE_W-1:0]) >= -UNIT_VALUE)
         && ($signed(rsp_tdata[FACE_W-1:0]) <= UNIT_VALUE)
         && ($signed(rsp_tdata[2*FACE_W-1:FACE_W]) >= -UNIT_VALUE)
         && ($signed(rsp_tdata[2*FACE_W-1:FACE_W]) <= UNIT_VALUE)
         && ($signed(rsp_tdata[3*FACE_W-1:2*FACE_W]) >= -UNIT_VALUE)
         && ($signed(rsp_tdata[3*FACE_W-1:2*FACE_W]) <= UNIT_VALUE))
      else $error("normal component out of range");

   // Nothing leaves the core right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input side only blocks while a result is held back
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input blocked without output stall");

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
